// File: rtl/hacw_pkg.sv
`default_nettype none
package hacw_pkg;

    // field widths
    localparam int HW    = 32;  // homography coefficient
    localparam int DIMW  = 14;  // frame dimension / window field
    localparam int NW    = 47;  // projective numerator / denominator, signed
    localparam int CRDW  = 32;  // projected coordinate, signed
    localparam int EXTW  = 33;  // bound extent, signed

    // corner quotient pipeline: 31 quotient bits, one per stage, plus a setup stage
    localparam int QBITS   = 31;
    localparam int DIV_LAT = QBITS + 1;

    // aspect crop divider: magnitude width and quotient bits per stage
    localparam int CQW       = 48;
    localparam int CROP_STEP = 4;
    localparam int CROP_STG  = CQW / CROP_STEP;

    // start to done, in cycles
    localparam int PIPE_LAT = 2 + DIV_LAT + 3 + CROP_STG + 3;

    // configuration register index (byte address bit 2)
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

endpackage
`default_nettype wire

// File: rtl/hacw_qdiv.sv
`default_nettype none
// Pipelined signed fixed-point quotient: num * 2^FRAC_BITS / den, truncated
// toward zero, magnitude saturated at 2^31-1, zero when den is zero.
module hacw_qdiv #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic signed [hacw_pkg::NW-1:0]      num,
    input  wire logic signed [hacw_pkg::NW-1:0]      den,
    output logic signed [hacw_pkg::CRDW-1:0]         quo
);
    localparam int NW    = hacw_pkg::NW;
    localparam int QBITS = hacw_pkg::QBITS;
    localparam int DW    = NW + FRAC_BITS;

    typedef struct packed {
        logic [NW-1:0]    r;
        logic [NW-1:0]    b;
        logic [QBITS-1:0] lo;
        logic [QBITS-1:0] q;
        logic             neg;
        logic             zero;
        logic             ovf;
    } dstage_t;

    dstage_t st_reg  [QBITS+1];
    dstage_t st_next [QBITS+1];

    logic [NW-1:0]    a_mag;
    logic [NW-1:0]    b_mag;
    logic [DW-1:0]    dvd;
    logic [QBITS-1:0] f_val;

    // setup: magnitudes, overflow test on the high dividend part;
    // then one restoring step per stage, quotient MSB first
    always_comb
    begin
        logic [NW:0] t;
        a_mag = num[NW-1] ? NW'(-num) : NW'(num);
        b_mag = den[NW-1] ? NW'(-den) : NW'(den);
        dvd   = {a_mag, {FRAC_BITS{1'b0}}};
        st_next[0].b    = b_mag;
        st_next[0].r    = NW'(dvd[DW-1:QBITS]);
        st_next[0].lo   = dvd[QBITS-1:0];
        st_next[0].q    = '0;
        st_next[0].neg  = num[NW-1] ^ den[NW-1];
        st_next[0].zero = (den == '0);
        st_next[0].ovf  = (NW'(dvd[DW-1:QBITS]) >= b_mag);
        for (int s = 1; s <= QBITS; s++)
        begin
            st_next[s] = st_reg[s-1];
            t = {st_reg[s-1].r, st_reg[s-1].lo[QBITS-s]};
            if (t >= {1'b0, st_reg[s-1].b})
            begin
                st_next[s].r          = NW'(t - {1'b0, st_reg[s-1].b});
                st_next[s].q[QBITS-s] = 1'b1;
            end
            else
            begin
                st_next[s].r = t[NW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    // saturate and apply sign
    always_comb
    begin
        if (st_reg[QBITS].zero)
            f_val = '0;
        else if (st_reg[QBITS].ovf)
            f_val = '1;
        else
            f_val = st_reg[QBITS].q;
        quo = st_reg[QBITS].neg ? -$signed({1'b0, f_val}) : $signed({1'b0, f_val});
    end

endmodule
`default_nettype wire

// File: rtl/homography_aspect_crop_window.sv
`default_nettype none
// Crop window for a perspective-warped frame. Pulse start with a Q16.16
// homography on h00..h22; busy is never raised, so a new matrix may be given
// every cycle. At the end of the pipeline done pulses for one cycle with
// roi_x/roi_y/roi_width/roi_height and warp_failed; there is no backpressure,
// so the result must be captured in that cycle. The pipeline holds the
// corner projection divide (a setup stage and one quotient bit per stage over
// 31 stages) and the aspect crop divide (four quotient bits per stage over
// 12 stages). frame_width sits at byte address 0, frame_height at 4; write
// them only while no matrix is in flight.
module homography_aspect_crop_window #(
    parameter int MAX_DIM   = 8192,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // command
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [31:0] h00,
    input  wire logic signed [31:0] h01,
    input  wire logic signed [31:0] h02,
    input  wire logic signed [31:0] h10,
    input  wire logic signed [31:0] h11,
    input  wire logic signed [31:0] h12,
    input  wire logic signed [31:0] h20,
    input  wire logic signed [31:0] h21,
    input  wire logic signed [31:0] h22,
    // result
    output logic             done,
    output logic [13:0]      roi_x,
    output logic [13:0]      roi_y,
    output logic [13:0]      roi_width,
    output logic [13:0]      roi_height,
    output logic             warp_failed
);
    localparam int NW       = hacw_pkg::NW;
    localparam int DIMW     = hacw_pkg::DIMW;
    localparam int CRDW     = hacw_pkg::CRDW;
    localparam int EXTW     = hacw_pkg::EXTW;
    localparam int CQW      = hacw_pkg::CQW;
    localparam int CW       = CQW + 1;
    localparam int XW       = CW + 3;
    localparam int PW       = EXTW + DIMW + 1;
    localparam int CSTG     = hacw_pkg::CROP_STG;
    localparam int CSTEP    = hacw_pkg::CROP_STEP;
    localparam int PLAT     = hacw_pkg::PIPE_LAT;
    localparam int DIM_CAP  = (MAX_DIM > 16383) ? 16383 : MAX_DIM;

    // ---------------- configuration ----------------
    logic [DIMW-1:0] fw_reg, fh_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= DIMW'(1920);
            fh_reg <= DIMW'(1080);
        end
        else if (cfg_wr)
        begin
            unique case (hacw_pkg::reg_idx_t'(paddr[2]))
                hacw_pkg::REG_FRAME_WIDTH:  fw_reg <= pwdata[DIMW-1:0];
                hacw_pkg::REG_FRAME_HEIGHT: fh_reg <= pwdata[DIMW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (hacw_pkg::reg_idx_t'(paddr[2]))
            hacw_pkg::REG_FRAME_WIDTH:  prdata = {{(32-DIMW){1'b0}}, fw_reg};
            hacw_pkg::REG_FRAME_HEIGHT: prdata = {{(32-DIMW){1'b0}}, fh_reg};
            default:                    prdata = '0;
        endcase
    end

    // effective dimension: zero reads as one, capped at MAX_DIM (at most 16383)
    function automatic logic [DIMW-1:0] eff_dim(input logic [DIMW-1:0] d);
        logic [DIMW-1:0] v;
        v = (d == '0) ? DIMW'(1) : d;
        if (v > DIMW'(DIM_CAP))
            v = DIMW'(DIM_CAP);
        return v;
    endfunction

    // signed divide by 2^s, truncated toward zero
    function automatic logic signed [XW-1:0] trunc_sh(input logic signed [XW-1:0] v,
                                                      input int s);
        logic signed [XW-1:0] bias;
        bias = v[XW-1] ? $signed((XW'(1) << s) - XW'(1)) : '0;
        return (v + bias) >>> s;
    endfunction

    logic [DIMW-1:0] w_eff, h_eff;
    logic signed [DIMW:0] w_s, h_s;

    assign w_eff = eff_dim(fw_reg);
    assign h_eff = eff_dim(fh_reg);
    assign w_s   = $signed({1'b0, w_eff});
    assign h_s   = $signed({1'b0, h_eff});

    // ---------------- valid line ----------------
    logic [PLAT-2:0] vpipe_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpipe_reg <= '0;
        else
            vpipe_reg <= {vpipe_reg[PLAT-3:0], start};
    end

    // ---------------- S1: coefficient products ----------------
    logic signed [NW-1:0] m0_reg, m1_reg, m3_reg, m4_reg, m6_reg, m7_reg;
    logic signed [31:0]   c2_reg, c5_reg, c8_reg;

    always_ff @(posedge clk)
    begin
        m0_reg <= NW'(h00) * NW'(w_s);
        m1_reg <= NW'(h01) * NW'(h_s);
        m3_reg <= NW'(h10) * NW'(w_s);
        m4_reg <= NW'(h11) * NW'(h_s);
        m6_reg <= NW'(h20) * NW'(w_s);
        m7_reg <= NW'(h21) * NW'(h_s);
        c2_reg <= h02;
        c5_reg <= h12;
        c8_reg <= h22;
    end

    // ---------------- S2: corner numerators and denominators ----------------
    // corners: 0 (0,0), 1 (W,0), 2 (W,H), 3 (0,H)
    logic signed [NW-1:0] nx_reg [4];
    logic signed [NW-1:0] ny_reg [4];
    logic signed [NW-1:0] dd_reg [4];

    always_ff @(posedge clk)
    begin
        nx_reg[0] <= NW'(c2_reg);
        nx_reg[1] <= m0_reg + NW'(c2_reg);
        nx_reg[2] <= m0_reg + m1_reg + NW'(c2_reg);
        nx_reg[3] <= m1_reg + NW'(c2_reg);
        ny_reg[0] <= NW'(c5_reg);
        ny_reg[1] <= m3_reg + NW'(c5_reg);
        ny_reg[2] <= m3_reg + m4_reg + NW'(c5_reg);
        ny_reg[3] <= m4_reg + NW'(c5_reg);
        dd_reg[0] <= NW'(c8_reg);
        dd_reg[1] <= m6_reg + NW'(c8_reg);
        dd_reg[2] <= m6_reg + m7_reg + NW'(c8_reg);
        dd_reg[3] <= m7_reg + NW'(c8_reg);
    end

    // ---------------- projection dividers ----------------
    logic signed [CRDW-1:0] px [4];
    logic signed [CRDW-1:0] py [4];

    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        hacw_qdiv #(.FRAC_BITS(FRAC_BITS)) u_divx (
            .clk (clk),
            .num (nx_reg[c]),
            .den (dd_reg[c]),
            .quo (px[c])
        );
        hacw_qdiv #(.FRAC_BITS(FRAC_BITS)) u_divy (
            .clk (clk),
            .num (ny_reg[c]),
            .den (dd_reg[c]),
            .quo (py[c])
        );
    end

    // ---------------- S3: inner bounds ----------------
    logic signed [CRDW-1:0] b_top, b_bot, b_left, b_right;
    logic signed [CRDW-1:0] left3_reg, top3_reg;
    logic signed [EXTW-1:0] wc3_reg, hc3_reg;

    always_comb
    begin
        b_top   = (py[0] > py[1]) ? py[0] : py[1];
        b_bot   = (py[2] < py[3]) ? py[2] : py[3];
        b_left  = (px[0] > px[3]) ? px[0] : px[3];
        b_right = (px[1] < px[2]) ? px[1] : px[2];
    end

    always_ff @(posedge clk)
    begin
        left3_reg <= b_left;
        top3_reg  <= b_top;
        wc3_reg   <= EXTW'(b_right) - EXTW'(b_left);
        hc3_reg   <= EXTW'(b_bot) - EXTW'(b_top);
    end

    // ---------------- S4: aspect cross products ----------------
    logic signed [PW-1:0]   pa4_reg, pb4_reg;
    logic signed [CRDW-1:0] left4_reg, top4_reg;
    logic signed [EXTW-1:0] wc4_reg, hc4_reg;

    always_ff @(posedge clk)
    begin
        pa4_reg   <= PW'(hc3_reg) * PW'(w_s);
        pb4_reg   <= PW'(wc3_reg) * PW'(h_s);
        left4_reg <= left3_reg;
        top4_reg  <= top3_reg;
        wc4_reg   <= wc3_reg;
        hc4_reg   <= hc3_reg;
    end

    // ---------------- S5: pick limiting side ----------------
    typedef struct packed {
        logic [CQW-1:0]         n;
        logic [DIMW-1:0]        rem;
        logic [DIMW-1:0]        d;
        logic                   neg;
        logic                   by_w;
        logic signed [EXTW-1:0] kept;
        logic signed [CRDW-1:0] left;
        logic signed [CRDW-1:0] btop;
        logic signed [EXTW-1:0] wc;
        logic signed [EXTW-1:0] hc;
    } cstage_t;

    cstage_t s5_reg;
    cstage_t s5_next;
    logic signed [PW-1:0] sel_num;

    always_comb
    begin
        s5_next.by_w = (pa4_reg > pb4_reg);
        sel_num      = s5_next.by_w ? pb4_reg : pa4_reg;
        s5_next.d    = s5_next.by_w ? w_eff : h_eff;
        s5_next.kept = s5_next.by_w ? wc4_reg : hc4_reg;
        s5_next.neg  = sel_num[PW-1];
        s5_next.n    = sel_num[PW-1] ? CQW'(-sel_num) : CQW'(sel_num);
        s5_next.rem  = '0;
        s5_next.left = left4_reg;
        s5_next.btop = top4_reg;
        s5_next.wc   = wc4_reg;
        s5_next.hc   = hc4_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_reg <= s5_next;
    end

    // ---------------- crop divider: CSTEP quotient bits per stage ----------------
    cstage_t cs_reg  [CSTG];
    cstage_t cs_next [CSTG];

    always_comb
    begin
        logic [DIMW:0] t;
        for (int s = 0; s < CSTG; s++)
        begin
            cs_next[s] = (s == 0) ? s5_reg : cs_reg[(s == 0) ? 0 : s-1];
            for (int k = 0; k < CSTEP; k++)
            begin
                t = {cs_next[s].rem, cs_next[s].n[CQW-1]};
                cs_next[s].n = {cs_next[s].n[CQW-2:0], 1'b0};
                if (t >= {1'b0, cs_next[s].d})
                begin
                    cs_next[s].rem  = DIMW'(t - {1'b0, cs_next[s].d});
                    cs_next[s].n[0] = 1'b1;
                end
                else
                begin
                    cs_next[s].rem = t[DIMW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg <= cs_next;
    end

    // ---------------- S6: signed crop sizes ----------------
    logic signed [CW-1:0]   quo_s;
    logic signed [CW-1:0]   wcrop6_reg, hcrop6_reg;
    logic signed [CRDW-1:0] left6_reg, top6_reg;
    logic signed [EXTW-1:0] wc6_reg, hc6_reg;

    assign quo_s = cs_reg[CSTG-1].neg ? -$signed({1'b0, cs_reg[CSTG-1].n})
                                      : $signed({1'b0, cs_reg[CSTG-1].n});

    always_ff @(posedge clk)
    begin
        wcrop6_reg <= cs_reg[CSTG-1].by_w ? CW'(cs_reg[CSTG-1].kept) : quo_s;
        hcrop6_reg <= cs_reg[CSTG-1].by_w ? quo_s : CW'(cs_reg[CSTG-1].kept);
        left6_reg  <= cs_reg[CSTG-1].left;
        top6_reg   <= cs_reg[CSTG-1].btop;
        wc6_reg    <= cs_reg[CSTG-1].wc;
        hc6_reg    <= cs_reg[CSTG-1].hc;
    end

    // ---------------- S7: whole-pixel position and size ----------------
    logic signed [XW-1:0] sx, sy;
    logic signed [XW-1:0] rx7_reg, ry7_reg, rw7_reg, rh7_reg;

    assign sx = (XW'(left6_reg) <<< 1) + XW'(wc6_reg) - XW'(wcrop6_reg);
    assign sy = (XW'(top6_reg) <<< 1) + XW'(hc6_reg) - XW'(hcrop6_reg);

    always_ff @(posedge clk)
    begin
        rx7_reg <= trunc_sh(sx, FRAC_BITS + 1);
        ry7_reg <= trunc_sh(sy, FRAC_BITS + 1);
        rw7_reg <= trunc_sh(XW'(wcrop6_reg), FRAC_BITS);
        rh7_reg <= trunc_sh(XW'(hcrop6_reg), FRAC_BITS);
    end

    // ---------------- S8: clamp to frame, fallback, output beat ----------------
    logic signed [XW-1:0] w_x, h_x;
    logic signed [XW-1:0] rx8, ry8, rw8, rh8;
    logic                 fail8;
    logic                 done_reg;
    logic [DIMW-1:0]      x_reg, y_reg, wd_reg, ht_reg;
    logic                 fail_reg;

    assign w_x = XW'(w_s);
    assign h_x = XW'(h_s);

    always_comb
    begin
        rx8   = rx7_reg[XW-1] ? '0 : rx7_reg;
        ry8   = ry7_reg[XW-1] ? '0 : ry7_reg;
        rw8   = (rx8 + rw7_reg >= w_x) ? w_x - rx8 : rw7_reg;
        rh8   = (ry8 + rh7_reg >= h_x) ? h_x - ry8 : rh7_reg;
        fail8 = rw8[XW-1] || rh8[XW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vpipe_reg[PLAT-2];
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= fail8 ? '0    : rx8[DIMW-1:0];
        y_reg    <= fail8 ? '0    : ry8[DIMW-1:0];
        wd_reg   <= fail8 ? w_eff : rw8[DIMW-1:0];
        ht_reg   <= fail8 ? h_eff : rh8[DIMW-1:0];
        fail_reg <= fail8;
    end

    assign done        = done_reg;
    assign roi_x       = x_reg;
    assign roi_y       = y_reg;
    assign roi_width   = wd_reg;
    assign roi_height  = ht_reg;
    assign warp_failed = fail_reg;

endmodule
`default_nettype wire

// File: rtl/hacw_chk.sv
`default_nettype none
module hacw_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        pready,
    input wire logic        done,
    input wire logic [13:0] roi_x,
    input wire logic [13:0] roi_y,
    input wire logic [13:0] roi_width,
    input wire logic        warp_failed
);
    localparam int LAT = hacw_pkg::PIPE_LAT;
    localparam int CNTW = $clog2(LAT + 1);

    // cycles since reset, saturating at the pipeline latency
    logic [CNTW-1:0] warm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            warm_reg <= '0;
        else if (warm_reg != CNTW'(LAT))
            warm_reg <= warm_reg + CNTW'(1);
    end

    // every command beat yields exactly one result beat a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg == CNTW'(LAT)) |-> (done == $past(start && !busy, LAT)))
        else $error("result beat does not match command beat");

    // fallback window (the full frame) is at the origin with a nonzero width
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        (done && warp_failed) |-> (roi_x == 14'd0 && roi_y == 14'd0 && roi_width != 14'd0))
        else $error("fallback window not at origin");

    // block never stalls commands
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind homography_aspect_crop_window hacw_chk u_hacw_chk (.*);
`default_nettype wire

// File: tb/homography_aspect_crop_window_tb.sv
`default_nettype none
module homography_aspect_crop_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_MAX = 64'd2147483647;
    localparam int     SETTLE    = hacw_pkg::PIPE_LAT + 10;

    typedef struct {
        logic signed [31:0] c [9];
    } matrix_t;

    typedef struct {
        logic [13:0] x;
        logic [13:0] y;
        logic [13:0] w;
        logic [13:0] h;
        logic        fail;
    } window_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        done;
    logic [13:0] roi_x;
    logic [13:0] roi_y;
    logic [13:0] roi_width;
    logic [13:0] roi_height;
    logic        warp_failed;

    matrix_t     cur_mat;
    matrix_t     pending_mats [$];
    window_t     expected_windows [$];
    logic [13:0] dim_w;
    logic [13:0] dim_h;
    int          idle_pct;
    bit          hold_off;
    bit          took;
    int          mismatches;
    int          i;

    homography_aspect_crop_window u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .h00        (cur_mat.c[0]),
        .h01        (cur_mat.c[1]),
        .h02        (cur_mat.c[2]),
        .h10        (cur_mat.c[3]),
        .h11        (cur_mat.c[4]),
        .h12        (cur_mat.c[5]),
        .h20        (cur_mat.c[6]),
        .h21        (cur_mat.c[7]),
        .h22        (cur_mat.c[8]),
        .done       (done),
        .roi_x      (roi_x),
        .roi_y      (roi_y),
        .roi_width  (roi_width),
        .roi_height (roi_height),
        .warp_failed(warp_failed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // signed quotient with 16 fraction bits, truncated, saturated; 0 on zero divisor
    function automatic longint fixed_quotient(longint num, longint den);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ip;
        logic [63:0] r;
        logic [63:0] f;
        bit          neg;
        int          k;
        if (den == 0 || num == 0)
            return 0;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        ip = a / b;
        r = a % b;
        if (ip > (COORD_MAX >> 16))
            f = COORD_MAX;
        else
        begin
            f = 0;
            for (k = 0; k < 16; k++)
            begin
                r = r << 1;
                f = f << 1;
                if (r >= b)
                begin
                    r = r - b;
                    f[0] = 1'b1;
                end
            end
            f = f | (ip << 16);
            if (f > COORD_MAX)
                f = COORD_MAX;
        end
        return neg ? -longint'(f) : longint'(f);
    endfunction

    function automatic longint clamp_dim(logic [13:0] d);
        if (d < 1)
            return 1;
        if (d > 8192)
            return 8192;
        return d;
    endfunction

    // crop window for one homography under the current frame size
    function automatic window_t crop_window(matrix_t m, logic [13:0] rw_reg,
                                            logic [13:0] rh_reg);
        longint  hm [9];
        longint  px [4];
        longint  py [4];
        longint  cx [4];
        longint  cy [4];
        longint  fw, fh, nx, ny, dd;
        longint  top, bottom, left, right, wc, hc, wcrop, hcrop;
        longint  rx, ry, rw, rh;
        window_t res;
        int      k;
        fw = clamp_dim(rw_reg);
        fh = clamp_dim(rh_reg);
        for (k = 0; k < 9; k++)
            hm[k] = m.c[k];
        cx = '{0, fw, fw, 0};
        cy = '{0, 0, fh, fh};
        for (k = 0; k < 4; k++)
        begin
            nx = hm[0] * cx[k] + hm[1] * cy[k] + hm[2];
            ny = hm[3] * cx[k] + hm[4] * cy[k] + hm[5];
            dd = hm[6] * cx[k] + hm[7] * cy[k] + hm[8];
            px[k] = fixed_quotient(nx, dd);
            py[k] = fixed_quotient(ny, dd);
        end
        top    = (py[0] > py[1]) ? py[0] : py[1];
        bottom = (py[2] < py[3]) ? py[2] : py[3];
        left   = (px[0] > px[3]) ? px[0] : px[3];
        right  = (px[1] < px[2]) ? px[1] : px[2];
        wc = right - left;
        hc = bottom - top;
        if (hc * fw > wc * fh)
        begin
            wcrop = wc;
            hcrop = wc * fh / fw;
        end
        else
        begin
            hcrop = hc;
            wcrop = hc * fw / fh;
        end
        rx = (2 * left + wc - wcrop) / 131072;
        ry = (2 * top + hc - hcrop) / 131072;
        rw = wcrop / 65536;
        rh = hcrop / 65536;
        if (rx < 0)
            rx = 0;
        if (rx + rw >= fw)
            rw = fw - rx;
        if (ry < 0)
            ry = 0;
        if (ry + rh >= fh)
            rh = fh - ry;
        res.fail = 1'b0;
        if (rw < 0 || rh < 0)
        begin
            rx = 0;
            ry = 0;
            rw = fw;
            rh = fh;
            res.fail = 1'b1;
        end
        res.x = rx[13:0];
        res.y = ry[13:0];
        res.w = rw[13:0];
        res.h = rh[13:0];
        return res;
    endfunction

    function automatic int spread(int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    function automatic logic [31:0] corner_value();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return 32'h0001_0000;
            6: return 32'hFFFF_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly near-identity warps, some raw noise, some extreme coefficients
    function automatic matrix_t random_matrix();
        matrix_t m;
        int      sel;
        int      k;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            m.c[0] = 65536 + spread(16384);
            m.c[1] = spread(8192);
            m.c[2] = spread(300) * 65536 + spread(65535);
            m.c[3] = spread(8192);
            m.c[4] = 65536 + spread(16384);
            m.c[5] = spread(300) * 65536 + spread(65535);
            m.c[6] = spread(6);
            m.c[7] = spread(6);
            m.c[8] = 65536 + spread(4096);
        end
        else if (sel < 85)
        begin
            for (k = 0; k < 9; k++)
                m.c[k] = $urandom;
        end
        else
        begin
            for (k = 0; k < 9; k++)
                m.c[k] = corner_value();
        end
        return m;
    endfunction

    function automatic matrix_t make_matrix(int a, int b, int c, int d, int e, int f,
                                            int g, int h, int k);
        matrix_t m;
        m.c = '{a, b, c, d, e, f, g, h, k};
        return m;
    endfunction

    // append one matrix to the driver's pending list
    task automatic queue_matrix(matrix_t m);
        pending_mats.insert(pending_mats.size(), m);
    endtask

    task automatic apb_write(hacw_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_frame(logic [13:0] w, logic [13:0] h);
        apb_write(hacw_pkg::REG_FRAME_WIDTH, {18'h0, w});
        apb_write(hacw_pkg::REG_FRAME_HEIGHT, {18'h0, h});
        dim_w = w;
        dim_h = h;
    endtask

    task automatic drain();
        while (pending_mats.size() != 0 || start || expected_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(int count, int idle);
        int k;
        idle_pct = idle;
        for (k = 0; k < count; k++)
            queue_matrix(random_matrix());
        drain();
    endtask

    // command driver: new beat on the falling edge once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (pending_mats.size() != 0 && !hold_off && $urandom_range(99) >= idle_pct)
            begin
                cur_mat <= pending_mats.pop_front();
                start   <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // accept side: predict each accepted beat
    always @(posedge clk)
    begin
        took <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            expected_windows.insert(expected_windows.size(),
                                    crop_window(cur_mat, dim_w, dim_h));
    end

    // result monitor
    always @(posedge clk)
    begin
        window_t exp_w;
        if (rst_n && done)
        begin
            if (expected_windows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat x=%0d y=%0d w=%0d h=%0d f=%0b",
                             roi_x, roi_y, roi_width, roi_height, warp_failed);
            end
            else
            begin
                exp_w = expected_windows.pop_front();
                if (roi_x !== exp_w.x || roi_y !== exp_w.y || roi_width !== exp_w.w
                    || roi_height !== exp_w.h || warp_failed !== exp_w.fail)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"window mismatch: exp x=%0d y=%0d w=%0d h=%0d f=%0b,",
                                  " got x=%0d y=%0d w=%0d h=%0d f=%0b"},
                                 exp_w.x, exp_w.y, exp_w.w, exp_w.h, exp_w.fail,
                                 roi_x, roi_y, roi_width, roi_height, warp_failed);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        took       = 1'b0;
        hold_off   = 1'b0;
        idle_pct   = 0;
        mismatches = 0;
        dim_w      = 14'd1920;
        dim_h      = 14'd1080;
        for (i = 0; i < 9; i++)
            cur_mat.c[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identity, extremes, zero divisor, saturation, edge clamps, fallback
        queue_matrix(make_matrix(65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
        queue_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_matrix(make_matrix(65536, 0, 0, 0, 65536, 0, 0, 0, 0));
        queue_matrix(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        queue_matrix(make_matrix(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        queue_matrix(make_matrix(32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000, 32'h80000000));
        queue_matrix(make_matrix(32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 1));
        queue_matrix(make_matrix(-65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
        queue_matrix(make_matrix(65536, 0, 0, 0, -65536, 0, 0, 0, 65536));
        queue_matrix(make_matrix(65536, 0, -200 * 65536, 0, 65536, -100 * 65536,
                                 0, 0, 65536));
        queue_matrix(make_matrix(65536, 0, 300 * 65536, 0, 65536, 150 * 65536,
                                 0, 0, 65536));
        queue_matrix(make_matrix(32768, 0, 0, 0, 65536, 0, 0, 0, 65536));
        queue_matrix(make_matrix(65536, 0, 0, 0, 32768, 0, 0, 0, 65536));
        queue_matrix(make_matrix(63000, -5000, 1000000, 5000, 63000, -800000,
                                 3, -2, 65536));
        queue_matrix(make_matrix(65536, 0, 0, 0, 65536, 0, 34, 0, 0));
        queue_matrix(make_matrix(65536, 0, 0, 0, 65536, 0, -34, 20, 65536));
        queue_matrix(make_matrix(131072, 0, 0, 0, 131072, 0, 0, 0, -65536));
        run_phase(160, 0);

        // sender mostly idle, with one full pause until the pipeline drains
        set_frame(14'd640, 14'd480);
        idle_pct = 74;
        for (i = 0; i < 180; i++)
            queue_matrix(random_matrix());
        while (pending_mats.size() > 90)
            @(posedge clk);
        hold_off = 1'b1;
        while (start || expected_windows.size() != 0)
            @(posedge clk);
        hold_off = 1'b0;
        drain();

        set_frame(14'd8192, 14'd8192);
        run_phase(170, 15);
        set_frame(14'd0, 14'd0);
        run_phase(170, 0);
        set_frame(14'h3FFF, 14'd3);
        run_phase(170, 74);
        set_frame(14'd1, 14'd8192);
        run_phase(170, 15);
        set_frame(14'd7, 14'd5);
        run_phase(170, 0);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
